[sv/nfsvp_pkg.sv]
// ----------------------------------------------------------------------------
// nfsvp_pkg
// Shared types and constants for the nearest free slot victim picker.
// ----------------------------------------------------------------------------
package nfsvp_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 256;

  // field widths
  localparam int unsigned HINT_W   = 8;
  localparam int unsigned VICTIM_W = 8;
  localparam int unsigned COUNT_W  = 9;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [0:0]  REG_ACTIVE_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RST = 9'd256;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_ADV,
    ST_DONE
  } state_t;

  typedef enum logic {
    SIDE_LOW  = 1'b0,
    SIDE_HIGH = 1'b1
  } side_t;

endpackage

[sv/nearest_free_slot_victim_picker.sv]
// ----------------------------------------------------------------------------
// nearest_free_slot_victim_picker
// Keeps one failed bit per slot in a memory with one write and one read port
// and, for each hint beat, marks and returns the nearest working slot (lower
// slot wins a tie) or returns not-found. After reset a clearing pass zeroes
// the bitmap; no hint is taken meanwhile, register writes are. The hint is
// clamped to the active count minus one. One memory read per cycle drives the
// search: a hint is accepted in the idle state, its candidate is read and
// checked, and a free slot goes to the done state. Each further candidate
// passes through step, read and check, and a step past one end of the range
// passes through the step state once more. The done state waits for the
// result register to empty. The result sits in an output register, so the
// next hint can be accepted while the last result waits to be taken.
// ----------------------------------------------------------------------------
module nearest_free_slot_victim_picker
  import nfsvp_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // hint channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [HINT_W-1:0]     in_hint_index,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VICTIM_W-1:0]   out_victim_index,
  output logic                  out_found,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_SLOTS - 1);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_SLOTS);

  // registers
  state_t               state_r, state_nxt;
  side_t                side_r, side_nxt;
  logic [IW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [IW-1:0]        cand_r, cand_nxt;
  logic [IW-1:0]        hint_r, hint_nxt;
  logic [CW-1:0]        dist_r, dist_nxt;
  logic [VICTIM_W-1:0]  res_victim_r, res_victim_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VICTIM_W-1:0]  out_victim_r, out_victim_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]   active_count_r;
  logic                 rd_bit_r;

  // failed bitmap
  logic                 fail_mem [MAX_SLOTS];
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic                 wr_data;

  // datapath
  logic [CW-1:0]        eff_count;
  logic [CW-1:0]        cnt_ext;
  logic [CW-1:0]        hint_ext;
  logic [CW-1:0]        clamp_ext;
  logic [CW-1:0]        cand_ext;
  logic [CW-1:0]        hint_w;
  logic [CW-1:0]        adv_dist;
  side_t                adv_side;
  logic                 lo_ok;
  logic                 hi_ok;
  logic [CW-1:0]        lo_addr;
  logic [CW:0]          hi_sum;
  logic                 in_ready_c;
  logic                 cfg_wr;

  // configuration register
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_ACTIVE_COUNT) ?
                  APB_DATA_W'(active_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= ACTIVE_COUNT_RST;
    end else if (cfg_wr && paddr[APB_ADDR_W-1] == REG_ACTIVE_COUNT) begin
      active_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  // count saturates at the bitmap depth
  assign cnt_ext   = CW'(active_count_r);
  assign eff_count = (cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext;
  assign hint_ext  = CW'(in_hint_index);
  assign clamp_ext = (hint_ext >= eff_count) ? eff_count - 1'b1 : hint_ext;
  assign cand_ext  = CW'(cand_r);

  // next candidate: low side then high side at each distance
  assign hint_w   = CW'(hint_r);
  assign adv_dist = (side_r == SIDE_HIGH) ? dist_r + 1'b1 : dist_r;
  assign adv_side = (side_r == SIDE_HIGH) ? SIDE_LOW : SIDE_HIGH;
  assign lo_ok    = (hint_w >= adv_dist);
  assign lo_addr  = hint_w - adv_dist;
  assign hi_sum   = (CW + 1)'(hint_w) + (CW + 1)'(adv_dist);
  assign hi_ok    = (hi_sum < (CW + 1)'(eff_count));

  always_comb begin
    state_nxt      = state_r;
    side_nxt       = side_r;
    clr_addr_nxt   = clr_addr_r;
    cand_nxt       = cand_r;
    hint_nxt       = hint_r;
    dist_nxt       = dist_r;
    res_victim_nxt = res_victim_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_victim_nxt = out_victim_r;
    out_found_nxt  = out_found_r;
    wr_en          = 1'b0;
    wr_addr        = cand_r;
    wr_data        = 1'b1;
    in_ready_c     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_c = 1'b1;
        if (in_valid) begin
          if (eff_count == '0) begin
            res_victim_nxt = '0;
            res_found_nxt  = 1'b0;
            state_nxt      = ST_DONE;
          end else begin
            hint_nxt  = clamp_ext[IW-1:0];
            cand_nxt  = clamp_ext[IW-1:0];
            dist_nxt  = '0;
            side_nxt  = SIDE_HIGH;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (!rd_bit_r) begin
          wr_en          = 1'b1;
          res_victim_nxt = cand_ext[VICTIM_W-1:0];
          res_found_nxt  = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        side_nxt = adv_side;
        dist_nxt = adv_dist;
        if (!lo_ok && !hi_ok) begin
          // both directions ran off the active range
          res_victim_nxt = '0;
          res_found_nxt  = 1'b0;
          state_nxt      = ST_DONE;
        end else if (adv_side == SIDE_LOW && lo_ok) begin
          cand_nxt  = lo_addr[IW-1:0];
          state_nxt = ST_RD;
        end else if (adv_side == SIDE_HIGH && hi_ok) begin
          cand_nxt  = hi_sum[IW-1:0];
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_victim_nxt = res_victim_r;
          out_found_nxt  = res_found_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r       <= side_nxt;
    cand_r       <= cand_nxt;
    hint_r       <= hint_nxt;
    dist_r       <= dist_nxt;
    res_victim_r <= res_victim_nxt;
    res_found_r  <= res_found_nxt;
    out_victim_r <= out_victim_nxt;
    out_found_r  <= out_found_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fail_mem[wr_addr] <= wr_data;
    end
    rd_bit_r <= fail_mem[cand_r];
  end

  assign in_ready         = in_ready_c;
  assign out_valid        = out_valid_r;
  assign out_victim_index = out_victim_r;
  assign out_found        = out_found_r;

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("picker still ready after taking a hint beat");

  a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> cand_ext < eff_count)
    else $error("search read outside the active slots");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_victim_index == '0)
    else $error("not-found result carries a nonzero victim");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR |-> !in_ready && !out_valid)
    else $error("hint channel open during bitmap clear");
`endif

endmodule
